FILE: rtl/clr_pkg.sv
// Package with shared types and constants of the command line receiver.
package clr_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE     = 2'd0,
    CMD_TAKE     = 2'd1,
    CMD_LINK_ERR = 2'd2,
    CMD_RESET    = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic step;
    logic start_take;
    logic send_char;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic take_ok;
    logic last_char;
  } dp_sts_t;

endpackage

FILE: rtl/clr_if.sv
// Request and result channel interfaces of the command line receiver.
interface clr_req_if;
  logic                         valid;
  logic                         ready;
  logic [clr_pkg::CMD_W-1:0]    command;
  logic [clr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface clr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [clr_pkg::KIND_W-1:0]   kind;
  logic [clr_pkg::BYTE_W-1:0]   line_char;
  logic [clr_pkg::LEN_W-1:0]    fill_count;
  logic                         line_pending;
  logic                         last;

  modport source (output valid, output kind, output line_char, output fill_count,
                  output line_pending, output last, input ready);
  modport sink (input valid, input kind, input line_char, input fill_count,
                input line_pending, input last, output ready);
endinterface

FILE: rtl/clr_ram.sv
// Generic simple dual-port RAM with registered read.
module clr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/clr_ctrl.sv
// Controller state machine: request acceptance and line streaming sequence.
module clr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                is_take,
  input  clr_pkg::dp_sts_t    sts,
  output logic                in_ready,
  output clr_pkg::ctl_cmd_t   cmd
);

  typedef enum logic {
    IDLE,
    SEND
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE) && sts.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid && in_ready) begin
          if (is_take && sts.take_ok) begin
            cmd.start_take = 1'b1;
            state_next     = SEND;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      SEND: begin
        if (sts.out_free) begin
          cmd.send_char = 1'b1;
          if (sts.last_char) begin
            state_next = IDLE;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/clr_dp.sv
// Datapath: line lengths, pending mark, two-bank line RAM and result register.
module clr_dp #(
  parameter int LINE_CAP = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [clr_pkg::CMD_W-1:0]   command,
  input  logic [clr_pkg::BYTE_W-1:0]  rx_byte,
  input  clr_pkg::ctl_cmd_t           cmd,
  output clr_pkg::dp_sts_t            sts,
  clr_rsp_if.source                   rsp
);

  localparam int IDX_W = $clog2(LINE_CAP);
  localparam int ADDR_W = IDX_W + 1;
  localparam logic [clr_pkg::LEN_W-1:0] CAP = clr_pkg::LEN_W'(LINE_CAP);

  logic [clr_pkg::LEN_W-1:0] partial_len, partial_len_next;
  logic [clr_pkg::LEN_W-1:0] held_len, held_len_next;
  logic [clr_pkg::LEN_W-1:0] idx, idx_inc;
  logic                      pending, pending_next;
  logic                      wr_bank, wr_bank_next;
  logic                      we, re;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [clr_pkg::BYTE_W-1:0] rdata;
  logic                      is_eol, is_erase, is_print;

  assign is_eol   = (rx_byte == clr_pkg::CH_CR) || (rx_byte == clr_pkg::CH_LF);
  assign is_erase = (rx_byte == clr_pkg::CH_BS) || (rx_byte == clr_pkg::CH_DEL);
  assign is_print = (rx_byte == clr_pkg::CH_TAB) ||
                    ((rx_byte >= clr_pkg::CH_SPACE) && (rx_byte <= clr_pkg::CH_TILDE));

  assign idx_inc = idx + clr_pkg::LEN_W'(1);

  assign sts.out_free  = !rsp.valid || rsp.ready;
  assign sts.take_ok   = pending && (held_len != '0);
  assign sts.last_char = (idx_inc == held_len);

  always_comb begin
    partial_len_next = partial_len;
    held_len_next    = held_len;
    pending_next     = pending;
    wr_bank_next     = wr_bank;
    we               = 1'b0;
    if (cmd.step) begin
      unique case (clr_pkg::cmd_t'(command))
        clr_pkg::CMD_BYTE: begin
          if (!pending) begin
            if (is_eol) begin
              // A finished line swaps banks instead of copying characters.
              if (partial_len != '0) begin
                held_len_next    = partial_len;
                pending_next     = 1'b1;
                partial_len_next = '0;
                wr_bank_next     = ~wr_bank;
              end
            end else if (is_erase) begin
              if (partial_len != '0) begin
                partial_len_next = partial_len - clr_pkg::LEN_W'(1);
              end
            end else if (is_print) begin
              if (partial_len < CAP) begin
                we               = 1'b1;
                partial_len_next = partial_len + clr_pkg::LEN_W'(1);
              end else begin
                partial_len_next = '0;
              end
            end else begin
              partial_len_next = '0;
            end
          end
        end
        clr_pkg::CMD_TAKE: pending_next = 1'b0;
        clr_pkg::CMD_LINK_ERR: partial_len_next = '0;
        clr_pkg::CMD_RESET: begin
          partial_len_next = '0;
          pending_next     = 1'b0;
        end
      endcase
    end
    if (cmd.start_take) begin
      pending_next = 1'b0;
    end
  end

  assign waddr = {wr_bank, partial_len[IDX_W-1:0]};
  assign re    = cmd.start_take || (cmd.send_char && !sts.last_char);
  assign raddr = {~wr_bank, cmd.start_take ? {IDX_W{1'b0}} : idx_inc[IDX_W-1:0]};

  clr_ram #(
    .WIDTH (clr_pkg::BYTE_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (rx_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_len <= '0;
      held_len    <= '0;
      pending     <= 1'b0;
      wr_bank     <= 1'b0;
      idx         <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      partial_len <= partial_len_next;
      held_len    <= held_len_next;
      pending     <= pending_next;
      wr_bank     <= wr_bank_next;
      if (cmd.start_take) begin
        idx <= '0;
      end else if (cmd.send_char) begin
        idx <= idx_inc;
      end
      if (cmd.step || cmd.send_char) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rsp.kind         <= (clr_pkg::cmd_t'(command) == clr_pkg::CMD_TAKE) ?
                          clr_pkg::KIND_NONE : clr_pkg::KIND_STATUS;
      rsp.line_char    <= '0;
      rsp.fill_count   <= partial_len_next;
      rsp.line_pending <= pending_next;
      rsp.last         <= 1'b1;
    end else if (cmd.send_char) begin
      rsp.kind         <= clr_pkg::KIND_CHAR;
      rsp.line_char    <= rdata;
      rsp.fill_count   <= partial_len;
      rsp.line_pending <= pending;
      rsp.last         <= sts.last_char;
    end
  end

endmodule

FILE: rtl/command_line_receiver.sv
// Top level of the command line receiver: controller, datapath and checks.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        command, rx_byte
//   rsp      out  valid/ready        kind, line_char, fill_count, line_pending, last
//
// A byte, link error, reset or empty take request gives one result; such requests
// follow each other every cycle while rsp is being taken.
// Taking a line of n characters first reads the line RAM, then gives one character
// per cycle while rsp is being taken; req is held off meanwhile.
// Reset clears lengths and the pending mark at once; the line RAM needs no clearing.
// A stalled rsp holds its result and blocks new requests until it is taken.
module command_line_receiver #(
  parameter int LINE_MAX = 64
) (
  input  logic    clk,
  input  logic    rst,
  clr_req_if.sink req,
  clr_rsp_if.source rsp
);

  localparam int LINE_CAP = ((LINE_MAX - 1) > 63) ? 63 : (LINE_MAX - 1);

  clr_pkg::ctl_cmd_t ctl_cmd;
  clr_pkg::dp_sts_t  dp_sts;
  logic              is_take;

  assign is_take = (clr_pkg::cmd_t'(req.command) == clr_pkg::CMD_TAKE);

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .is_take  (is_take),
    .sts      (dp_sts),
    .in_ready (req.ready),
    .cmd      (ctl_cmd)
  );

  clr_dp #(
    .LINE_CAP (LINE_CAP)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .command (req.command),
    .rx_byte (req.rx_byte),
    .cmd     (ctl_cmd),
    .sts     (dp_sts),
    .rsp     (rsp)
  );

  // A character result always belongs to a line whose pending mark was cleared.
  a_char_not_pending: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind == clr_pkg::KIND_CHAR) |-> !rsp.line_pending)
    else $error("line character reported with a line still pending");

  // Non-character results are single and carry no character.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind != clr_pkg::KIND_CHAR) |-> rsp.last && (rsp.line_char == '0))
    else $error("status result without last marker or with a character");

  // No request is taken while a line is being streamed out.
  a_no_accept_in_stream: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.send_char |-> !(req.valid && req.ready))
    else $error("request accepted during line streaming");

  // The partial line never grows beyond its capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.fill_count <= clr_pkg::LEN_W'(LINE_CAP)))
    else $error("fill count above line capacity");

endmodule
